// ===== sv/bdps_pkg.sv =====
package bdps_pkg;

   localparam int HOURS_PER_DAY = 24;
   localparam int HOUR_W = 5;
   localparam int DIV_N_W = 32;
   localparam int DIV_D_W = 16;
   localparam int DIV_CNT_W = 6;

   localparam logic [6:0] MIN_DOSE_RESET = 7'd10;
   localparam logic [15:0] STEPS_RESET = 16'd100;
   // x / 100 == ((x >> 2) * 687194768) >> 34 for every x below 2**31
   localparam logic [29:0] HUNDREDTH_RECIP = 30'd687194768;
   localparam int HUNDREDTH_SHIFT = 34;
   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [15:0] TENTH_RECIP = 16'd52429;
   localparam int TENTH_SHIFT = 19;

   typedef enum logic [1:0] {
      OP_SET_HOUR = 2'd0,
      OP_TICK     = 2'd1,
      OP_ACTIVATE = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_MIN_DOSE = 1'b0,
      CSR_STEPS    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIV_COUNT    = 2'd0,
      DIV_INTERVAL = 2'd1,
      DIV_LIMIT    = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV_COUNT,
      ST_DIV_INTERVAL,
      ST_DIV_LIMIT,
      ST_MUL,
      ST_RECIP,
      ST_STEPS,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [13:0] target_hundredths;
      logic [5:0]  minute_now;
      logic [4:0]  hour_index;
      logic        bolus_request;
      logic [13:0] bolus_hundredths;
      logic        reverse_request;
   } req_type;

   typedef struct packed {
      logic        basal_fired;
      logic [23:0] forward_steps;
      logic [12:0] backward_steps;
      logic [15:0] hour_dose_count;
      logic [15:0] delivered_hour;
      logic [31:0] delivered_total;
      logic [11:0] interval_now;
      logic [11:0] dither_limit;
      logic        basal_enabled;
   } rsp_type;

   typedef struct packed {
      logic        load_item;
      logic        exec_tick;
      logic        exec_disable;
      logic        exec_activate;
      logic        latch_product;
      logic        latch_recip;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_count;
      logic        take_interval;
      logic        take_limit;
      logic        take_steps;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       set_disable;
      logic       div_busy;
      logic       rem_zero;
      logic       amount_zero;
   } status_type;

endpackage

// ===== sv/bdps_div.sv =====
module bdps_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bdps_pkg::DIV_N_W-1:0] dividend,
   input  logic [bdps_pkg::DIV_D_W-1:0] divisor,
   output logic                         busy,
   output logic [bdps_pkg::DIV_N_W-1:0] quotient,
   output logic [bdps_pkg::DIV_D_W-1:0] remainder
);
   import bdps_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_D_W:0]     trial;

   // one quotient bit a cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[DIV_N_W-1]} - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DIV_D_W]) begin
            rem_in = trial[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_D_W-2:0], quo_ff[DIV_N_W-1]};
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/bdps_datapath.sv =====
module bdps_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  bdps_pkg::req_type    req_data,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wr_data,
   input  bdps_pkg::cmd_type    cmd,
   output bdps_pkg::status_type status,
   output bdps_pkg::rsp_type    rsp_data
);
   import bdps_pkg::*;

   // configuration
   logic [6:0]  min_dose_ff;
   logic [15:0] steps_ff;
   logic [31:0] tenth_prod;
   logic [12:0] back_ff;

   // latched item
   req_type item_ff;

   // scheduler state
   logic [11:0] sec_ff, sec_in;
   logic [11:0] ivl_ff, ivl_in;
   logic [11:0] base_ff, base_in;
   logic [11:0] limit_ff, limit_in;
   logic [15:0] dose_cnt_ff, dose_cnt_in;
   logic [15:0] counts_ff [HOURS_PER_DAY];
   logic [15:0] counts_in [HOURS_PER_DAY];
   logic        pending_ff, pending_in;
   logic [15:0] hd_ff, hd_in;
   logic [31:0] total_ff, total_in;
   logic        enabled_ff, enabled_in;

   // working registers
   logic [13:0] count_ff;
   logic [14:0] amount_ff, amount_in;
   logic [30:0] product_ff;
   logic [58:0] recip_ff;
   logic        fired_ff, fired_in;
   logic [23:0] fwd_ff;
   rsp_type     rsp_ff;

   logic [6:0]  quantum;
   logic [16:0] remaining;
   logic [11:0] seconds;
   logic [5:0]  minute_cl;
   logic        hour_ok;
   logic [16:0] hd_sum;
   logic [11:0] sec_next;

   logic                 div_busy;
   logic [DIV_N_W-1:0]   div_quo;
   logic [DIV_D_W-1:0]   div_rem;
   logic [DIV_N_W-1:0]   div_dividend;
   logic [DIV_D_W-1:0]   div_divisor;

   assign quantum   = (min_dose_ff == 7'd0) ? 7'd1 : min_dose_ff;
   assign minute_cl = (item_ff.minute_now > 6'd59) ? 6'd59 : item_ff.minute_now;
   assign seconds   = 12'((7'd60 - {1'b0, minute_cl}) * 7'd60);
   assign remaining = {3'b000, item_ff.target_hundredths} - {1'b0, hd_ff};
   assign hour_ok   = (item_ff.hour_index < HOUR_W'(HOURS_PER_DAY));

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dose_ff <= MIN_DOSE_RESET;
         steps_ff    <= STEPS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_DOSE: min_dose_ff <= csr_wr_data[6:0];
            CSR_STEPS:    steps_ff    <= csr_wr_data;
            default:      ;
         endcase
      end
   end

   assign tenth_prod = steps_ff * TENTH_RECIP;

   always_ff @(posedge clock) begin
      back_ff <= tenth_prod[TENTH_SHIFT+12:TENTH_SHIFT];
   end

   always_comb begin
      case (cmd.div_sel)
         DIV_COUNT: begin
            div_dividend = DIV_N_W'(remaining[13:0]);
            div_divisor  = DIV_D_W'(quantum);
         end
         DIV_INTERVAL: begin
            div_dividend = DIV_N_W'(seconds);
            div_divisor  = DIV_D_W'(div_quo[13:0]);
         end
         default: begin
            div_dividend = DIV_N_W'({1'b0, count_ff, 1'b0} + {1'b0, div_rem});
            div_divisor  = {div_rem[DIV_D_W-2:0], 1'b0};
         end
      endcase
   end

   bdps_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      sec_in      = sec_ff;
      ivl_in      = ivl_ff;
      base_in     = base_ff;
      limit_in    = limit_ff;
      dose_cnt_in = dose_cnt_ff;
      counts_in   = counts_ff;
      pending_in  = pending_ff;
      hd_in       = hd_ff;
      total_in    = total_ff;
      enabled_in  = enabled_ff;
      amount_in   = amount_ff;
      fired_in    = fired_ff;
      sec_next    = sec_ff + 12'd1;
      hd_sum      = {1'b0, hd_ff} + 17'(quantum);

      if (cmd.load_item) begin
         fired_in = 1'b0;
      end
      if (cmd.exec_tick && enabled_ff && (ivl_ff != 12'd0)) begin
         sec_in = sec_next;
         if (sec_next == ivl_ff) begin
            dose_cnt_in = dose_cnt_ff + 16'd1;
            if (hour_ok) begin
               counts_in[item_ff.hour_index] = counts_ff[item_ff.hour_index] + 16'd1;
            end
            pending_in = 1'b1;
            sec_in     = '0;
            fired_in   = 1'b1;
         end
      end
      if (cmd.exec_disable) begin
         sec_in     = '0;
         enabled_in = 1'b0;
         base_in    = '0;
         ivl_in     = '0;
         limit_in   = '0;
      end
      if (cmd.take_interval) begin
         sec_in     = '0;
         enabled_in = 1'b1;
         base_in    = div_quo[11:0];
         ivl_in     = div_quo[11:0];
         limit_in   = '0;
      end
      if (cmd.take_limit) begin
         limit_in = div_quo[11:0];
      end
      if (cmd.exec_activate) begin
         amount_in = '0;
         if (pending_ff) begin
            pending_in = 1'b0;
            amount_in  = 15'(quantum);
            hd_in      = hd_sum[16] ? 16'hFFFF : hd_sum[15:0];
            if ((limit_ff != 12'd0) && (dose_cnt_ff == {4'b0000, limit_ff})) begin
               dose_cnt_in = 16'hFFFF;
               ivl_in      = base_ff + 12'd1;
            end else begin
               ivl_in = base_ff;
            end
         end
         if (item_ff.bolus_request) begin
            amount_in = amount_in + 15'(item_ff.bolus_hundredths);
         end
         total_in = total_ff + 32'(amount_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff      <= '0;
         ivl_ff      <= '0;
         base_ff     <= '0;
         limit_ff    <= '0;
         dose_cnt_ff <= '0;
         counts_ff   <= '{default: '0};
         pending_ff  <= 1'b0;
         hd_ff       <= '0;
         total_ff    <= '0;
         enabled_ff  <= 1'b0;
      end else begin
         sec_ff      <= sec_in;
         ivl_ff      <= ivl_in;
         base_ff     <= base_in;
         limit_ff    <= limit_in;
         dose_cnt_ff <= dose_cnt_in;
         counts_ff   <= counts_in;
         pending_ff  <= pending_in;
         hd_ff       <= hd_in;
         total_ff    <= total_in;
         enabled_ff  <= enabled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
         fwd_ff  <= '0;
      end else if (cmd.take_steps) begin
         fwd_ff <= recip_ff[HUNDREDTH_SHIFT+24] ? 24'hFFFFFF
                 : recip_ff[HUNDREDTH_SHIFT+23:HUNDREDTH_SHIFT];
      end
      if (cmd.take_count) begin
         count_ff <= div_quo[13:0];
      end
      if (cmd.latch_product) begin
         product_ff <= steps_ff * amount_ff;
      end
      // divide by 100 as a quarter then a reciprocal multiply by 1/25
      if (cmd.latch_recip) begin
         recip_ff <= product_ff[30:2] * HUNDREDTH_RECIP;
      end
      amount_ff <= amount_in;
      fired_ff  <= fired_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.basal_fired     <= fired_ff;
         rsp_ff.forward_steps   <= fwd_ff;
         rsp_ff.backward_steps  <= (opcode_type'(item_ff.opcode) == OP_ACTIVATE &&
                                    item_ff.reverse_request) ? back_ff : 13'd0;
         rsp_ff.hour_dose_count <= hour_ok ? counts_ff[item_ff.hour_index] : 16'd0;
         rsp_ff.delivered_hour  <= hd_ff;
         rsp_ff.delivered_total <= total_ff;
         rsp_ff.interval_now    <= ivl_ff;
         rsp_ff.dither_limit    <= limit_ff;
         rsp_ff.basal_enabled   <= enabled_ff;
      end
   end

   assign rsp_data = rsp_ff;

   assign status.opcode      = opcode_type'(item_ff.opcode);
   assign status.set_disable = $signed(remaining) < $signed({10'd0, quantum});
   assign status.div_busy    = div_busy;
   assign status.rem_zero    = (div_rem == '0);
   assign status.amount_zero = (amount_ff == '0);

endmodule

// ===== sv/bdps_ctrl.sv =====
module bdps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bdps_pkg::status_type status,
   output bdps_pkg::cmd_type    cmd
);
   import bdps_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            case (status.opcode)
               OP_SET_HOUR: state_in = status.set_disable ? ST_RESULT : ST_DIV_COUNT;
               OP_ACTIVATE: state_in = ST_MUL;
               default:     state_in = ST_RESULT;
            endcase
         end
         ST_DIV_COUNT:    if (!status.div_busy) state_in = ST_DIV_INTERVAL;
         ST_DIV_INTERVAL: begin
            if (!status.div_busy) state_in = status.rem_zero ? ST_RESULT : ST_DIV_LIMIT;
         end
         ST_DIV_LIMIT:    if (!status.div_busy) state_in = ST_RESULT;
         ST_MUL:          state_in = status.amount_zero ? ST_RESULT : ST_RECIP;
         ST_RECIP:        state_in = ST_STEPS;
         ST_STEPS:        state_in = ST_RESULT;
         ST_RESULT:       if (out_free) state_in = ST_IDLE;
         default:         state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = DIV_COUNT;
      case (state_ff)
         ST_IDLE: cmd.load_item = req_valid;
         ST_EXEC: begin
            case (status.opcode)
               OP_SET_HOUR: begin
                  cmd.exec_disable = status.set_disable;
                  cmd.div_start    = !status.set_disable;
               end
               OP_TICK:     cmd.exec_tick     = 1'b1;
               OP_ACTIVATE: cmd.exec_activate = 1'b1;
               default:     ;
            endcase
         end
         ST_DIV_COUNT: begin
            cmd.div_sel = DIV_INTERVAL;
            if (!status.div_busy) begin
               cmd.take_count = 1'b1;
               cmd.div_start  = 1'b1;
            end
         end
         ST_DIV_INTERVAL: begin
            cmd.div_sel = DIV_LIMIT;
            if (!status.div_busy) begin
               cmd.take_interval = 1'b1;
               cmd.div_start     = !status.rem_zero;
            end
         end
         ST_DIV_LIMIT:  cmd.take_limit = !status.div_busy;
         ST_MUL:        cmd.latch_product = 1'b1;
         ST_RECIP:      cmd.latch_recip = 1'b1;
         ST_STEPS:      cmd.take_steps = 1'b1;
         ST_RESULT:     cmd.load_rsp = out_free;
         default:       ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_RESULT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/basal_dose_pulse_scheduler.sv =====
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_data (req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data (rsp_type)
// csr       in         csr_wr_en              csr_index, csr_wr_data
//
// one item at a time; tick and idle opcodes go from exec straight to result.
// set hour uses one shared 32-bit restoring divider for count, interval and limit,
// one bit a cycle; activate runs multiply, reciprocal and steps, the last two
// skipped when nothing is delivered; the divide by 100 is a reciprocal multiply.
// a finished result sits in the output register while the next item is taken.
// synchronous reset clears the schedule, counters and per-hour counts.
module basal_dose_pulse_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdps_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wr_data
);
   import bdps_pkg::*;

   cmd_type    cmd;
   status_type status;

   bdps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bdps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule
